FILE: src/gmp_pkg.sv
// Shared types and constants for the grid minimum path cost and count block.
// No dependencies.
`default_nettype none

package gmp_pkg;

    // Field and register widths
    localparam int COST_W    = 16;
    localparam int ACC_W     = 32;
    localparam int COL_REG_W = 11;

    // Saturation value for path cost and path count
    localparam logic [ACC_W-1:0] SAT_VAL = {ACC_W{1'b1}};

    // Per-cell control carried from the read stage to the update stage
    typedef struct packed {
        logic first_row;
        logic col_zero;
        logic last;
    } cell_ctl_t;

endpackage

`default_nettype wire

FILE: src/grid_min_path_cost_and_count.sv
// Top level: streaming grid min-cost path cost and count with a row buffer.
// Depends on gmp_pkg (widths, saturation constant, stage control struct).
`default_nettype none

// Takes one grid cell per cycle, sustained, in row-major order. Each accepted
// word reads the row buffer entry for its column; the next cycle compares the
// cell above against the left neighbor and adds the cell cost, and the update
// stage writes the entry back when it fires; a last cell's result is registered
// into the output register from there. The row buffer
// read-modify-write sets the rate: one cell per cycle,
// with a forwarding path when the same column is read and written back to back
// (one-column grids, or a restart right after a first-column last cell). Input
// stalls only while a finished result waits in the output register and the next
// last cell needs it. The row buffer needs no clearing after reset. A column
// setting of zero acts as one; values above MAX_COLS act as MAX_COLS.
module grid_min_path_cost_and_count #(
    parameter int MAX_COLS = 1024
) (
    input  wire                             clk,
    input  wire                             rst_n,
    // configuration
    input  wire                             cfg_wr_en,
    input  wire  [gmp_pkg::COL_REG_W-1:0]   cfg_wr_data,
    // cell input channel
    input  wire                             in_valid,
    output logic                            in_ready,
    input  wire  [gmp_pkg::COST_W-1:0]      cell_cost,
    input  wire                             last_cell,
    // result channel
    output logic                            out_valid,
    input  wire                             out_ready,
    output logic [gmp_pkg::ACC_W-1:0]       min_cost,
    output logic [gmp_pkg::ACC_W-1:0]       path_count,
    output logic                            count_saturated
);
    import gmp_pkg::*;

    localparam int CIDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CNT_W  = ($clog2(MAX_COLS + 1) > COL_REG_W) ?
                            $clog2(MAX_COLS + 1) : COL_REG_W;
    localparam logic [CNT_W-1:0] MAX_COLS_C = CNT_W'(MAX_COLS);

    // Row buffer
    logic [ACC_W-1:0] cost_mem  [MAX_COLS];
    logic [ACC_W-1:0] count_mem [MAX_COLS];

    // Configuration and column tracking
    logic [COL_REG_W-1:0] cols_reg;
    logic [CIDX_W-1:0]    col_reg, col_next;
    logic                 first_row_reg, first_row_next;
    logic [CNT_W-1:0]     cols_eff;
    logic [CNT_W-1:0]     col_plus1;

    // Update stage
    logic                 s1_valid_reg;
    logic [COST_W-1:0]    s1_cost_reg;
    logic [CIDX_W-1:0]    s1_col_reg;
    cell_ctl_t            s1_ctl_reg;
    logic [ACC_W-1:0]     rd_cost_reg, rd_count_reg;
    logic                 byp_sel_reg;
    logic [ACC_W-1:0]     byp_cost_reg, byp_count_reg;
    logic [ACC_W-1:0]     left_cost_reg, left_count_reg;

    // Output register
    logic                 out_valid_reg;
    logic [ACC_W-1:0]     out_cost_reg, out_count_reg;
    logic                 out_sat_reg;

    logic                 s1_fire;
    logic                 accept;
    logic [ACC_W-1:0]     up_cost, up_count;
    logic [ACC_W-1:0]     base_cost, sel_count;
    logic [ACC_W:0]       count_sum;
    logic [ACC_W:0]       cost_sum;
    logic [ACC_W-1:0]     new_cost;

    // Handshake
    assign s1_fire  = s1_valid_reg && !(s1_ctl_reg.last && out_valid_reg && !out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;
    assign accept   = in_valid && in_ready;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= COL_REG_W'(1);
        end
        else if (cfg_wr_en)
        begin
            cols_reg <= cfg_wr_data;
        end
    end

    // Effective column count, clamped to 1..MAX_COLS
    always_comb
    begin
        if (cols_reg == '0)
        begin
            cols_eff = CNT_W'(1);
        end
        else if (CNT_W'(cols_reg) > MAX_COLS_C)
        begin
            cols_eff = MAX_COLS_C;
        end
        else
        begin
            cols_eff = CNT_W'(cols_reg);
        end
    end

    // Next column position
    assign col_plus1 = CNT_W'(col_reg) + CNT_W'(1);

    always_comb
    begin
        col_next       = col_reg;
        first_row_next = first_row_reg;
        if (last_cell)
        begin
            col_next       = '0;
            first_row_next = 1'b1;
        end
        else if (col_plus1 >= cols_eff)
        begin
            col_next       = '0;
            first_row_next = 1'b0;
        end
        else
        begin
            col_next = col_plus1[CIDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            first_row_reg <= 1'b1;
        end
        else if (accept)
        begin
            col_reg       <= col_next;
            first_row_reg <= first_row_next;
        end
    end

    // Row buffer read at accept, write back from the update stage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_cost_reg  <= cost_mem[col_reg];
            rd_count_reg <= count_mem[col_reg];
        end
        if (s1_fire)
        begin
            cost_mem[s1_col_reg]  <= new_cost;
            count_mem[s1_col_reg] <= sel_count;
        end
    end

    // Forward a write to the same column that is being read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_sel_reg <= 1'b0;
        end
        else if (accept)
        begin
            byp_sel_reg <= s1_fire && (s1_col_reg == col_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byp_cost_reg  <= new_cost;
            byp_count_reg <= sel_count;
        end
    end

    // Update stage registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cost_reg          <= cell_cost;
            s1_col_reg           <= col_reg;
            s1_ctl_reg.first_row <= first_row_reg;
            s1_ctl_reg.col_zero  <= (col_reg == '0);
            s1_ctl_reg.last      <= last_cell;
        end
    end

    // Best of up and left, tie adds counts
    assign up_cost   = byp_sel_reg ? byp_cost_reg  : rd_cost_reg;
    assign up_count  = byp_sel_reg ? byp_count_reg : rd_count_reg;
    assign count_sum = {1'b0, up_count} + {1'b0, left_count_reg};

    always_comb
    begin
        if (s1_ctl_reg.first_row && s1_ctl_reg.col_zero)
        begin
            base_cost = '0;
            sel_count = ACC_W'(1);
        end
        else if (s1_ctl_reg.first_row)
        begin
            base_cost = left_cost_reg;
            sel_count = left_count_reg;
        end
        else if (s1_ctl_reg.col_zero)
        begin
            base_cost = up_cost;
            sel_count = up_count;
        end
        else if (up_cost == left_cost_reg)
        begin
            base_cost = up_cost;
            sel_count = count_sum[ACC_W] ? SAT_VAL : count_sum[ACC_W-1:0];
        end
        else if (up_cost < left_cost_reg)
        begin
            base_cost = up_cost;
            sel_count = up_count;
        end
        else
        begin
            base_cost = left_cost_reg;
            sel_count = left_count_reg;
        end
    end

    // Saturating cost add
    assign cost_sum = {1'b0, base_cost} + (ACC_W + 1)'(s1_cost_reg);
    assign new_cost = cost_sum[ACC_W] ? SAT_VAL : cost_sum[ACC_W-1:0];

    // Left neighbor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_cost_reg  <= '0;
            left_count_reg <= '0;
        end
        else if (s1_fire)
        begin
            left_cost_reg  <= new_cost;
            left_count_reg <= sel_count;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && s1_ctl_reg.last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_ctl_reg.last)
        begin
            out_cost_reg  <= new_cost;
            out_count_reg <= sel_count;
            out_sat_reg   <= (sel_count == SAT_VAL);
        end
    end

    assign out_valid       = out_valid_reg;
    assign min_cost        = out_cost_reg;
    assign path_count      = out_count_reg;
    assign count_saturated = out_sat_reg;

    // Checks
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_fire) |-> !in_ready)
        else $error("input taken while update stage is stalled");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_ctl_reg.last) |-> (!out_valid_reg || out_ready))
        else $error("pending result overwritten");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(col_reg) < MAX_COLS)
        else $error("column index beyond row buffer");

    a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_cell) |=> (col_reg == '0 && first_row_reg))
        else $error("grid did not restart after last cell");

endmodule

`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for grid_min_path_cost_and_count: streams grids, predicts
// min path cost and count per grid, and checks each result word.
// Depends on gmp_pkg and the grid_min_path_cost_and_count top level.

module tb;

    import gmp_pkg::*;

    localparam int MAX_COLS   = 1024;
    localparam int SETTLE_CYC = 8;
    localparam int LONG_HOLD  = 300;

    typedef struct packed {
        logic [ACC_W-1:0] cost;
        logic [ACC_W-1:0] count;
        logic             sat;
    } path_result_t;

    typedef enum int {COST_FULL, COST_TINY, COST_SPARSE, COST_MIXED} cost_style_t;

    // Tracks the DP state of the grid in flight and holds the awaited results
    class grid_cost_tracker;
        bit [ACC_W-1:0] above_cost [MAX_COLS];
        bit [ACC_W-1:0] above_count [MAX_COLS];
        bit [ACC_W-1:0] left_cost;
        bit [ACC_W-1:0] left_count;
        int unsigned    col_pos;
        int unsigned    eff_cols;
        bit             top_row;
        path_result_t   awaited [$];
        int             fail_count;

        function new();
            eff_cols   = 1;
            fail_count = 0;
            restart();
        endfunction

        function void restart();
            col_pos    = 0;
            top_row    = 1'b1;
            left_cost  = '0;
            left_count = '0;
        endfunction

        // Zero behaves as one column; anything wider than the buffer is clamped
        function void set_columns(bit [COL_REG_W-1:0] value);
            if (value == 0)
                eff_cols = 1;
            else if (value > MAX_COLS)
                eff_cols = MAX_COLS;
            else
                eff_cols = value;
        endfunction

        function bit [ACC_W-1:0] add_sat(bit [ACC_W-1:0] a, bit [ACC_W-1:0] b);
            bit [ACC_W:0] sum;
            sum = {1'b0, a} + {1'b0, b};
            return sum[ACC_W] ? SAT_VAL : sum[ACC_W-1:0];
        endfunction

        // One accepted cell word: pick best of up/left, add cost, update buffers
        function void take_cell(logic [COST_W-1:0] cost, logic is_last);
            int unsigned    col;
            bit [ACC_W-1:0] base;
            bit [ACC_W-1:0] cnt;
            path_result_t   res;
            col = col_pos;
            if (top_row && col == 0)
            begin
                base = '0;
                cnt  = 1;
            end
            else if (top_row)
            begin
                base = left_cost;
                cnt  = left_count;
            end
            else if (col == 0)
            begin
                base = above_cost[col];
                cnt  = above_count[col];
            end
            else if (above_cost[col] == left_cost)
            begin
                base = left_cost;
                cnt  = add_sat(above_count[col], left_count);
            end
            else if (above_cost[col] < left_cost)
            begin
                base = above_cost[col];
                cnt  = above_count[col];
            end
            else
            begin
                base = left_cost;
                cnt  = left_count;
            end
            base = add_sat(base, {{(ACC_W-COST_W){1'b0}}, cost});
            above_cost[col]  = base;
            above_count[col] = cnt;
            left_cost        = base;
            left_count       = cnt;
            if (is_last)
            begin
                res.cost  = base;
                res.count = cnt;
                res.sat   = (cnt == SAT_VAL);
                awaited.push_back(res);
                restart();
            end
            else if (col + 1 >= eff_cols)
            begin
                col_pos = 0;
                top_row = 1'b0;
            end
            else
                col_pos = col + 1;
        endfunction

        function void flag_error(string msg);
            fail_count++;
            if (fail_count <= 10)
                $display("ERROR: %s", msg);
        endfunction

        function void match_result(logic [ACC_W-1:0] cost, logic [ACC_W-1:0] cnt, logic sat);
            path_result_t want;
            if (awaited.size() == 0)
            begin
                flag_error($sformatf("unexpected result: min_cost %0d path_count %0d sat %b",
                                     cost, cnt, sat));
                return;
            end
            want = awaited.pop_front();
            if (cost !== want.cost)
                flag_error($sformatf("min_cost: expected %0d, got %0d", want.cost, cost));
            if (cnt !== want.count)
                flag_error($sformatf("path_count: expected %0d, got %0d", want.count, cnt));
            if (sat !== want.sat)
                flag_error($sformatf("count_saturated: expected %b, got %b", want.sat, sat));
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [COL_REG_W-1:0] cfg_wr_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [COST_W-1:0]    cell_cost = '0;
    logic                 last_cell = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [ACC_W-1:0]     min_cost;
    logic [ACC_W-1:0]     path_count;
    logic                 count_saturated;

    grid_cost_tracker tracker = new();

    int unsigned burst_left = 0;
    int unsigned hold_ticket = 0;
    bit          wide_done = 1'b0;

    grid_min_path_cost_and_count #(
        .MAX_COLS(MAX_COLS)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cell_cost      (cell_cost),
        .last_cell      (last_cell),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .min_cost       (min_cost),
        .path_count     (path_count),
        .count_saturated(count_saturated)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.match_result(min_cost, path_count, count_saturated);
    end

    // Result sink: random ready modes, plus a long hold-off on request
    initial
    begin : result_sink
        int unsigned served;
        int unsigned hold_left;
        int unsigned mode_left;
        int unsigned mode;
        served    = 0;
        hold_left = 0;
        mode_left = 0;
        mode      = 0;
        forever
        begin
            @(posedge clk);
            if (hold_ticket != served)
            begin
                served    = hold_ticket;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(32, 256);
                end
                mode_left--;
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 9) < 7);
                    default: out_ready <= ($urandom_range(0, 9) < 2);
                endcase
            end
        end
    end

    function automatic logic [COST_W-1:0] pick_cost(cost_style_t style);
        case (style)
            COST_FULL:   return COST_W'($urandom_range(0, 65535));
            COST_TINY:   return COST_W'($urandom_range(0, 3));
            COST_SPARSE: return ($urandom_range(0, 7) == 0) ? COST_W'(1) : COST_W'(0);
            default:     return ($urandom_range(0, 4) == 0) ? COST_W'($urandom_range(0, 65535))
                                                            : COST_W'($urandom_range(0, 7));
        endcase
    endfunction

    // Offer one cell word; sender runs in bursts with random gaps between them
    task automatic send_cell(input logic [COST_W-1:0] cost, input logic is_last);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid  <= 1'b1;
        cell_cost <= cost;
        last_cell <= is_last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tracker.take_cell(cost, is_last);
    endtask

    // n cells of one cost, last mark on the final one
    task automatic send_run(input int unsigned n, input logic [COST_W-1:0] cost);
        for (int unsigned k = 1; k <= n; k++)
            send_cell(cost, k == n);
    endtask

    // Column register write, only once the block has drained
    task automatic write_columns(input int unsigned value);
        in_valid <= 1'b0;
        while (tracker.awaited.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value[COL_REG_W-1:0];
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        tracker.set_columns(value[COL_REG_W-1:0]);
        burst_left = 0;
    endtask

    // One column setting, then a few grids; some end early on the last mark
    task automatic random_phase(inout int unsigned cells_sent, inout int unsigned grids_sent);
        int unsigned sel;
        int unsigned reg_val;
        int unsigned width;
        int unsigned grids;
        int unsigned rows;
        int unsigned stop_at;
        cost_style_t style;
        sel = $urandom_range(0, 99);
        if (sel < 6)
            reg_val = 0;
        else if (sel < 12)
            reg_val = 1;
        else if (sel < 15 && !wide_done)
        begin
            reg_val   = $urandom_range(0, 1) ? MAX_COLS : $urandom_range(MAX_COLS + 1, 2047);
            wide_done = 1'b1;
        end
        else if (sel < 75)
            reg_val = $urandom_range(2, 8);
        else if (sel < 92)
            reg_val = $urandom_range(9, 24);
        else
            reg_val = $urandom_range(25, 80);
        write_columns(reg_val);
        width = tracker.eff_cols;
        grids = (width > 24) ? 1 : $urandom_range(1, 6);
        repeat (grids)
        begin
            rows    = (width > 24) ? $urandom_range(1, 2) : $urandom_range(1, 5);
            if (width > 100)
                stop_at = $urandom_range(1, 48);
            else
                stop_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, rows * width)
                                                      : rows * width;
            style   = cost_style_t'($urandom_range(0, 3));
            for (int unsigned k = 1; k <= stop_at; k++)
                send_cell(pick_cost(style), k == stop_at);
            cells_sent += stop_at;
            grids_sent++;
        end
    endtask

    initial
    begin : stimulus
        int unsigned rnd_cells;
        int unsigned rnd_grids;
        logic [COST_W-1:0] mixed_grid [9];
        rnd_cells  = 0;
        rnd_grids  = 0;
        mixed_grid = '{16'd1, 16'd2, 16'd3, 16'd4, 16'd0, 16'd1, 16'd2, 16'd2, 16'd0};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset column setting of one: single-cell grids at both cost extremes
        send_cell(16'h0000, 1'b1);
        send_cell(16'hFFFF, 1'b1);

        // 3x3: all ties, then mixed up/left winners, then a last mark mid-row
        write_columns(3);
        send_run(9, COST_W'(1));
        for (int k = 0; k < 9; k++)
            send_cell(mixed_grid[k], k == 8);
        for (int k = 0; k < 5; k++)
            send_cell(COST_W'(5 + k), k == 4);

        // zero columns act as one
        write_columns(0);
        send_cell(16'd7, 1'b0);
        send_cell(16'd8, 1'b0);
        send_cell(16'd9, 1'b1);

        // oversize register clamps to the full buffer width; short first row
        write_columns(2047);
        for (int k = 0; k < 40; k++)
            send_cell(pick_cost(COST_FULL), k == 39);

        // zero-cost 18x19 grid: path count runs past saturation
        write_columns(19);
        send_run(18 * 19, COST_W'(0));

        // one column of max costs, same entry read and written back to back
        write_columns(1);
        send_run(6, 16'hFFFF);

        // receiver holds off while single-cell grids keep coming
        hold_ticket++;
        repeat (60) send_cell(pick_cost(COST_FULL), 1'b1);

        while (rnd_cells < 250 || rnd_grids < 20)
            random_phase(rnd_cells, rnd_grids);

        in_valid <= 1'b0;
        while (tracker.awaited.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (tracker.fail_count == 0 && tracker.awaited.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Run limit
    initial
    begin : watchdog
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
